// File: hdl/token_splitter_with_comments_macros.svh
// ----------------------------------------------------------------------------
// Token splitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOKEN_SPLITTER_WITH_COMMENTS_MACROS_SVH
`define TOKEN_SPLITTER_WITH_COMMENTS_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TKS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TKS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TKS_ASSERT_IMP(lbl, ante, cons)
`define TKS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/tks_pkg.sv
// ----------------------------------------------------------------------------
// Token splitter package
// Types, character codes and result helpers shared by the splitter modules.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int TOKEN_LIMIT_DEF = 128;
	localparam int COUNT_W         = 8;
	localparam int MAX_RES         = 3;

	localparam logic [7:0] CH_NUL     = 8'd0;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_QUOTE   = 8'd34;
	localparam logic [7:0] CH_SLASH   = 8'd47;

	typedef enum logic [2:0] {
		MODE_SKIP    = 3'd0,
		MODE_SLASH   = 3'd1,
		MODE_COMMENT = 3'd2,
		MODE_QUOTE   = 3'd3,
		MODE_WORD    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_END    = 2'd1,
		KIND_BUFEND = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          char_value;
		logic [COUNT_W-1:0]  token_length;
		logic                overflow;
		logic                last;
	} result_t;

	function automatic result_t mk_byte(input logic [7:0] c);
		result_t r;
		r = '0;
		r.kind       = KIND_BYTE;
		r.char_value = c;
		return r;
	endfunction

	function automatic result_t mk_end(input logic [COUNT_W-1:0] len, input logic ov);
		result_t r;
		r = '0;
		r.kind         = KIND_END;
		r.token_length = len;
		r.overflow     = ov;
		return r;
	endfunction

	function automatic result_t mk_bufend();
		result_t r;
		r = '0;
		r.kind = KIND_BUFEND;
		return r;
	endfunction

endpackage

// File: hdl/tks_step.sv
// ----------------------------------------------------------------------------
// Token splitter step logic
// Decodes one byte against the scan mode and token count into up to three
// results and the next mode and count.
// ----------------------------------------------------------------------------
module tks_step #(
	parameter int TOKEN_LIMIT = tks_pkg::TOKEN_LIMIT_DEF
) (
	input  tks_pkg::mode_t                  mode,
	input  logic [tks_pkg::COUNT_W-1:0]     count,
	input  logic [7:0]                      text_byte,
	output tks_pkg::mode_t                  mode_d,
	output logic [tks_pkg::COUNT_W-1:0]     count_d,
	output logic [1:0]                      res_n,
	output tks_pkg::result_t                res [tks_pkg::MAX_RES]
);

	localparam logic [tks_pkg::COUNT_W-1:0] LIMIT_C  = TOKEN_LIMIT[tks_pkg::COUNT_W-1:0];
	localparam logic [tks_pkg::COUNT_W-1:0] QLIMIT_C = LIMIT_C - 8'd1;

	tks_pkg::result_t r [tks_pkg::MAX_RES];
	logic [1:0]       n;

	always_comb begin
		n       = 2'd0;
		mode_d  = mode;
		count_d = count;
		for (int i = 0; i < tks_pkg::MAX_RES; i++) r[i] = '0;

		unique case (mode)
			tks_pkg::MODE_SLASH: begin
				if (text_byte == tks_pkg::CH_SLASH) begin
					mode_d = tks_pkg::MODE_COMMENT;
				end else begin
					// lone slash starts a token; both bytes fit if the limit is two or more
					r[0] = tks_pkg::mk_byte(tks_pkg::CH_SLASH);
					if (text_byte > tks_pkg::CH_SPACE) begin
						r[1]    = tks_pkg::mk_byte(text_byte);
						n       = 2'd2;
						mode_d  = tks_pkg::MODE_WORD;
						count_d = 8'd2;
					end else begin
						r[1]    = tks_pkg::mk_end(8'd1, 1'b0);
						mode_d  = tks_pkg::MODE_SKIP;
						count_d = '0;
						if (text_byte == tks_pkg::CH_NUL) begin
							r[2] = tks_pkg::mk_bufend();
							n    = 2'd3;
						end else begin
							n = 2'd2;
						end
					end
				end
			end
			tks_pkg::MODE_COMMENT: begin
				if (text_byte == tks_pkg::CH_NUL) begin
					r[0]    = tks_pkg::mk_bufend();
					n       = 2'd1;
					mode_d  = tks_pkg::MODE_SKIP;
					count_d = '0;
				end else if (text_byte == tks_pkg::CH_NEWLINE) begin
					mode_d = tks_pkg::MODE_SKIP;
				end
			end
			tks_pkg::MODE_QUOTE: begin
				if (text_byte == tks_pkg::CH_QUOTE || text_byte == tks_pkg::CH_NUL) begin
					r[0]    = tks_pkg::mk_end(count, 1'b0);
					mode_d  = tks_pkg::MODE_SKIP;
					count_d = '0;
					if (text_byte == tks_pkg::CH_NUL) begin
						r[1] = tks_pkg::mk_bufend();
						n    = 2'd2;
					end else begin
						n = 2'd1;
					end
				end else if (count < QLIMIT_C) begin
					r[0]    = tks_pkg::mk_byte(text_byte);
					n       = 2'd1;
					count_d = count + 8'd1;
				end
			end
			tks_pkg::MODE_WORD: begin
				if (text_byte > tks_pkg::CH_SPACE) begin
					if (count < LIMIT_C) begin
						r[0]    = tks_pkg::mk_byte(text_byte);
						n       = 2'd1;
						count_d = count + 8'd1;
					end
				end else begin
					r[0]    = (count >= LIMIT_C) ? tks_pkg::mk_end('0, 1'b1)
					                              : tks_pkg::mk_end(count, 1'b0);
					mode_d  = tks_pkg::MODE_SKIP;
					count_d = '0;
					if (text_byte == tks_pkg::CH_NUL) begin
						r[1] = tks_pkg::mk_bufend();
						n    = 2'd2;
					end else begin
						n = 2'd1;
					end
				end
			end
			default: begin
				mode_d = tks_pkg::MODE_SKIP;
				if (text_byte == tks_pkg::CH_NUL) begin
					r[0]    = tks_pkg::mk_bufend();
					n       = 2'd1;
					count_d = '0;
				end else if (text_byte <= tks_pkg::CH_SPACE) begin
					// whitespace
				end else if (text_byte == tks_pkg::CH_SLASH) begin
					mode_d = tks_pkg::MODE_SLASH;
				end else if (text_byte == tks_pkg::CH_QUOTE) begin
					mode_d  = tks_pkg::MODE_QUOTE;
					count_d = '0;
				end else begin
					r[0]    = tks_pkg::mk_byte(text_byte);
					n       = 2'd1;
					mode_d  = tks_pkg::MODE_WORD;
					count_d = 8'd1;
				end
			end
		endcase

		case (n)
			2'd1:    r[0].last = 1'b1;
			2'd2:    r[1].last = 1'b1;
			2'd3:    r[2].last = 1'b1;
			default: ;
		endcase
	end

	assign res_n = n;
	assign res   = r;

endmodule

// File: hdl/tks_out_queue.sv
// ----------------------------------------------------------------------------
// Token splitter result queue
// Holds the results of one byte in registers and hands them out in order.
// ----------------------------------------------------------------------------
`include "token_splitter_with_comments_macros.svh"

module tks_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        push_n,
	input  tks_pkg::result_t  push_res [tks_pkg::MAX_RES],
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output tks_pkg::result_t  head
);

	tks_pkg::result_t slot_q [tks_pkg::MAX_RES];
	logic [1:0]       cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	// a new item may load once the last held result leaves this cycle
	assign can_push  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign head      = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q <= push_res;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	`TKS_ASSERT_IMP(a_last_on_final, cnt_q == 2'd1, slot_q[0].last)
	`TKS_ASSERT_IMP(a_no_early_last, cnt_q > 2'd1, !slot_q[0].last)
	`TKS_ASSERT_NXT(a_push_shows, push && push_n != 2'd0, out_valid)
	`TKS_ASSERT_NXT(a_empty_push, push && push_n == 2'd0, !out_valid)

endmodule

// File: hdl/token_splitter_with_comments.sv
// The first result of an item is on the output ports in the cycle after it is accepted.
// One byte per cycle while each byte yields at most one result and out_ready is high; a byte
// that yields two or three results holds the input until the single result port has drained
// all but the last of them from the result queue.
// Reset (arst_n low, asynchronous): skip-whitespace mode, token count zero, queue empty.
// ----------------------------------------------------------------------------
// Token splitter top level
// Streams buffer bytes into tokens, skipping whitespace and line comments.
// ----------------------------------------------------------------------------
`include "token_splitter_with_comments_macros.svh"

module token_splitter_with_comments #(
	parameter int TOKEN_LIMIT = tks_pkg::TOKEN_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  char_value,
	output logic [7:0]  token_length,
	output logic        overflow,
	output logic        last
);

	localparam logic [tks_pkg::COUNT_W-1:0] LIMIT_C = TOKEN_LIMIT[tks_pkg::COUNT_W-1:0];

	tks_pkg::mode_t               mode_q, mode_d;
	logic [tks_pkg::COUNT_W-1:0]  count_q, count_d;
	logic [1:0]                   res_n;
	tks_pkg::result_t             res [tks_pkg::MAX_RES];
	tks_pkg::result_t             head;
	logic                         accept;

	assign accept = in_valid && in_ready;

	tks_step #(
		.TOKEN_LIMIT (TOKEN_LIMIT)
	) u_step (
		.mode      (mode_q),
		.count     (count_q),
		.text_byte (text_byte),
		.mode_d    (mode_d),
		.count_d   (count_d),
		.res_n     (res_n),
		.res       (res)
	);

	tks_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_n    (res_n),
		.push_res  (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tks_pkg::MODE_SKIP;
			count_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	assign kind         = head.kind;
	assign char_value   = head.char_value;
	assign token_length = head.token_length;
	assign overflow     = head.overflow;
	assign last         = head.last;

	`TKS_ASSERT_IMP(a_idle_count, mode_q == tks_pkg::MODE_SKIP || mode_q == tks_pkg::MODE_SLASH || mode_q == tks_pkg::MODE_COMMENT, count_q == '0)
	`TKS_ASSERT_IMP(a_word_count, mode_q == tks_pkg::MODE_WORD, count_q != '0 && count_q <= LIMIT_C)
	`TKS_ASSERT_IMP(a_quote_count, mode_q == tks_pkg::MODE_QUOTE, count_q < LIMIT_C)

endmodule
